@@ rtl/fcce_pkg.sv @@
`timescale 1ns / 1ps

package fcce_pkg;

  localparam int CLUSTERS = 4096;
  localparam int ADDR_W   = $clog2(CLUSTERS);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int DATA_W   = 28;
  localparam int CLUS_W   = 12;
  localparam int KIND_W   = 2;
  localparam int CFG_W    = 12;
  localparam int CIDX_W   = 1;

  localparam logic [DATA_W-1:0] MASK12 = 28'h0000FFF;
  localparam logic [DATA_W-1:0] MASK16 = 28'h000FFFF;
  localparam logic [DATA_W-1:0] MASK28 = 28'hFFFFFFF;
  localparam logic [DATA_W-1:0] EOC12  = 28'h0000FF8;
  localparam logic [DATA_W-1:0] EOC16  = 28'h000FFF8;
  localparam logic [DATA_W-1:0] EOC28  = 28'hFFFFFF8;

  localparam logic [KIND_W-1:0] KIND_FAT12 = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FAT16 = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FAT32 = 2'd2;

  localparam logic [1:0] OP_NEXT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_END     = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_RUNAWAY = 2'd3;

  localparam logic [1:0] SRC_ZERO  = 2'd0;
  localparam logic [1:0] SRC_CUR   = 2'd1;
  localparam logic [1:0] SRC_ENTRY = 2'd2;

  localparam logic [CIDX_W-1:0] REG_FAT_KIND      = 1'd0;
  localparam logic [CIDX_W-1:0] REG_CLUSTER_COUNT = 1'd1;

  typedef struct packed {
    logic       capture;
    logic       clear_wr;
    logic       adv_search;
    logic       alloc_mark;
    logic       link_wr;
    logic       free_step;
    logic       write_entry;
    logic       respond;
    logic [1:0] resp_status;
    logic [1:0] resp_src;
  } fcce_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       link;
    logic       entry_free;
    logic       entry_end;
    logic       search_last;
    logic       steps_last;
    logic       clear_last;
  } fcce_stat_t;

  function automatic logic [DATA_W-1:0] width_mask(input logic [KIND_W-1:0] kind);
    logic [DATA_W-1:0] m;
    case (kind)
      KIND_FAT12: m = MASK12;
      KIND_FAT16: m = MASK16;
      default:    m = MASK28;
    endcase
    return m;
  endfunction

  function automatic logic [DATA_W-1:0] end_threshold(input logic [KIND_W-1:0] kind);
    logic [DATA_W-1:0] t;
    case (kind)
      KIND_FAT12: t = EOC12;
      KIND_FAT16: t = EOC16;
      default:    t = EOC28;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/fat_cluster_chain_engine.sv @@
`timescale 1ns / 1ps

// Cluster allocation table engine. After reset the table is swept to all free,
// one entry a cycle, so busy stays high for the whole sweep before the first
// request is taken. A request is taken when start is high and busy is low;
// its result shows on status and cluster_out for exactly one cycle with done
// high, and must be captured then. The table sits in a single memory with a
// registered read. A write entry finishes from the read state; next cluster
// passes the read and check states, allocate passes them for each cluster
// examined (plus the link state when linking), and free chain passes them
// for each entry of the chain. A new request may be given in the cycle that
// done is high. Configuration writes are taken at any time but are meant
// for an idle engine.
module fat_cluster_chain_engine
  import fcce_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        opcode,
  input  logic [CLUS_W-1:0] cluster,
  input  logic              link_after,
  input  logic [DATA_W-1:0] entry_value,
  output logic              done,
  output logic [1:0]        status,
  output logic [DATA_W-1:0] cluster_out
);

  fcce_cmd_t  cmd;
  fcce_stat_t stat;

  fcce_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  fcce_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .opcode     (opcode),
    .cluster    (cluster),
    .link_after (link_after),
    .entry_value(entry_value),
    .cmd        (cmd),
    .stat       (stat),
    .done       (done),
    .status     (status),
    .cluster_out(cluster_out)
  );

endmodule

@@ rtl/fcce_ram.sv @@
`timescale 1ns / 1ps

module fcce_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/fcce_ctrl.sv @@
`timescale 1ns / 1ps

module fcce_ctrl
  import fcce_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  fcce_stat_t stat,
  output fcce_cmd_t  cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_LINK  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        if (stat.op == OP_WRITE) begin
          cmd.write_entry = 1'b1;
          cmd.respond     = 1'b1;
          cmd.resp_status = STAT_OK;
          cmd.resp_src    = SRC_ZERO;
          state_next      = ST_IDLE;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        case (stat.op)
          OP_NEXT: begin
            cmd.respond     = 1'b1;
            cmd.resp_status = stat.entry_end ? STAT_END : STAT_OK;
            cmd.resp_src    = stat.entry_end ? SRC_ZERO : SRC_ENTRY;
            state_next      = ST_IDLE;
          end
          OP_ALLOC: begin
            if (stat.entry_free) begin
              cmd.alloc_mark = 1'b1;
              if (stat.link) begin
                state_next = ST_LINK;
              end else begin
                cmd.respond     = 1'b1;
                cmd.resp_status = STAT_OK;
                cmd.resp_src    = SRC_CUR;
                state_next      = ST_IDLE;
              end
            end else if (stat.search_last) begin
              cmd.respond     = 1'b1;
              cmd.resp_status = STAT_FULL;
              cmd.resp_src    = SRC_ZERO;
              state_next      = ST_IDLE;
            end else begin
              cmd.adv_search = 1'b1;
              state_next     = ST_READ;
            end
          end
          OP_FREE: begin
            cmd.free_step = 1'b1;
            if (stat.entry_end) begin
              cmd.respond     = 1'b1;
              cmd.resp_status = STAT_OK;
              cmd.resp_src    = SRC_ZERO;
              state_next      = ST_IDLE;
            end else if (stat.steps_last) begin
              cmd.respond     = 1'b1;
              cmd.resp_status = STAT_RUNAWAY;
              cmd.resp_src    = SRC_ZERO;
              state_next      = ST_IDLE;
            end else begin
              state_next = ST_READ;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_LINK: begin
        cmd.link_wr     = 1'b1;
        cmd.respond     = 1'b1;
        cmd.resp_status = STAT_OK;
        cmd.resp_src    = SRC_CUR;
        state_next      = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/fcce_datapath.sv @@
`timescale 1ns / 1ps

module fcce_datapath
  import fcce_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [1:0]        opcode,
  input  logic [CLUS_W-1:0] cluster,
  input  logic              link_after,
  input  logic [DATA_W-1:0] entry_value,
  input  fcce_cmd_t         cmd,
  output fcce_stat_t        stat,
  output logic              done,
  output logic [1:0]        status,
  output logic [DATA_W-1:0] cluster_out
);

  logic [KIND_W-1:0] fat_kind;
  logic [CLUS_W-1:0] cluster_count;
  logic [ADDR_W-1:0] search_start;
  logic [ADDR_W-1:0] clear_addr;

  logic [1:0]        op;
  logic [ADDR_W-1:0] clus;
  logic              link;
  logic [DATA_W-1:0] val;
  logic [ADDR_W-1:0] cur;
  logic [CNT_W-1:0]  tries;
  logic [CNT_W-1:0]  steps;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] rdata;

  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] entry;
  logic [ADDR_W:0]   cur_inc;
  logic [ADDR_W-1:0] cur_adv;

  assign mask    = width_mask(fat_kind);
  assign entry   = rdata & mask;
  assign cur_inc = {1'b0, cur} + {{ADDR_W{1'b0}}, 1'b1};
  // wrap to zero once past the highest searchable cluster
  assign cur_adv = (cur_inc > {{(ADDR_W + 1 - CLUS_W){1'b0}}, cluster_count}) ?
                   '0 : cur_inc[ADDR_W-1:0];

  assign stat.op          = op;
  assign stat.link        = link;
  assign stat.entry_free  = (entry == '0);
  assign stat.entry_end   = (entry >= end_threshold(fat_kind));
  assign stat.search_last = (cur_adv == search_start) || (tries == CNT_W'(CLUSTERS));
  assign stat.steps_last  = (steps == CNT_W'(CLUSTERS - 1));
  assign stat.clear_last  = (clear_addr == ADDR_W'(CLUSTERS - 1));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur;
    ram_wdata = '0;
    if (cmd.clear_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clear_addr;
    end else if (cmd.alloc_mark) begin
      ram_we    = 1'b1;
      ram_wdata = mask;
    end else if (cmd.link_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clus;
      ram_wdata = DATA_W'(cur) & mask;
    end else if (cmd.free_step) begin
      ram_we    = 1'b1;
    end else if (cmd.write_entry) begin
      ram_we    = 1'b1;
      ram_waddr = clus;
      ram_wdata = val & mask;
    end
  end

  fcce_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CLUSTERS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cur),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fat_kind      <= KIND_FAT32;
      cluster_count <= CLUS_W'(4095);
      search_start  <= '0;
      clear_addr    <= '0;
      done          <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FAT_KIND:      fat_kind <= cfg_data[KIND_W-1:0];
          REG_CLUSTER_COUNT: cluster_count <= cfg_data[CLUS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clear_wr) begin
        clear_addr <= clear_addr + ADDR_W'(1);
      end
      if (cmd.alloc_mark) begin
        search_start <= cur;
      end
      done <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= opcode;
      clus  <= cluster[ADDR_W-1:0];
      link  <= link_after;
      val   <= entry_value;
      cur   <= (opcode == OP_ALLOC) ? search_start : cluster[ADDR_W-1:0];
      tries <= '0;
      steps <= '0;
    end else if (cmd.adv_search) begin
      cur   <= cur_adv;
      tries <= tries + CNT_W'(1);
    end else if (cmd.free_step) begin
      // follow the link just read
      cur   <= entry[ADDR_W-1:0];
      steps <= steps + CNT_W'(1);
    end
    if (cmd.respond) begin
      status <= cmd.resp_status;
      case (cmd.resp_src)
        SRC_CUR:   cluster_out <= DATA_W'(cur);
        SRC_ENTRY: cluster_out <= entry;
        default:   cluster_out <= '0;
      endcase
    end
  end

endmodule

@@ rtl/fcce_checker.sv @@
`timescale 1ns / 1ps

module fcce_checker
  import fcce_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [1:0]        status,
  input logic [DATA_W-1:0] cluster_out
);

  // a taken request makes the engine busy in the next cycle
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but engine not busy");

  // results come out only when the engine has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe on two adjacent cycles");

  // end of chain, full table and runaway all report a zero cluster
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_OK) |-> (cluster_out == '0))
    else $error("non-zero cluster with failing status");

endmodule

bind fat_cluster_chain_engine fcce_checker u_fcce_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .status     (status),
  .cluster_out(cluster_out)
);
